// ===== sv/dtmfseq_pkg.sv =====
`timescale 1ns / 1ps

package dtmfseq_pkg;

    // sizing
    localparam int CODE_DIGITS  = 4;
    localparam int TIMER_BITS   = 16;
    localparam int DIGIT_IDX_W  = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
    localparam int CODE_EXT_W   = 8 * CODE_DIGITS + 32;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 8;

    // register reset values
    localparam logic [31:0] CODE_RESET   = 32'd842348579;
    localparam logic [15:0] GUARD_RESET  = 16'd30000;
    localparam logic [15:0] HANGUP_RESET = 16'd1000;

    localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

    typedef logic [TIMER_BITS-1:0]  timer_t;
    typedef logic [DIGIT_IDX_W-1:0] digit_idx_t;

    typedef enum logic [2:0] {
        OP_START        = 3'd0,
        OP_TICK         = 3'd1,
        OP_MODEM_OK     = 3'd2,
        OP_DIGIT        = 3'd3,
        OP_CARRIER_LOST = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        CMD_NONE      = 3'd0,
        CMD_DDET_ON   = 3'd1,
        CMD_ANSWER    = 3'd2,
        CMD_TONE_LEN  = 3'd3,
        CMD_SEND_TONE = 3'd4,
        CMD_HANG_UP   = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        EXIT_RUNNING = 2'd0,
        EXIT_RESET   = 2'd1,
        EXIT_DELAYED = 2'd2
    } exit_t;

    typedef enum logic [1:0] {
        REG_CODE_DIGITS = 2'd0,
        REG_GUARD_TICKS = 2'd1,
        REG_HANGUP_TICKS = 2'd2
    } reg_idx_t;

    typedef enum logic [4:0] {
        PH_IDLE         = 5'd0,
        PH_WAIT_DDET_OK = 5'd1,
        PH_WAIT_ATA_OK  = 5'd2,
        PH_DIGITS       = 5'd3,
        PH_WAIT_VTD_OK  = 5'd12,
        PH_WAIT_VTS_OK  = 5'd13,
        PH_DELAY_HANGUP = 5'd14,
        PH_WAIT_ATH_OK  = 5'd15,
        PH_FINAL_DELAY  = 5'd16,
        PH_RESET_DELAY  = 5'd17,
        PH_DONE_RESET   = 5'd18,
        PH_DONE_DELAYED = 5'd19
    } phase_t;

    typedef struct packed {
        logic [7:0] digit;
        logic [2:0] op;
    } item_t;

    typedef struct packed {
        exit_t exit_mode;
        cmd_t  command;
    } result_t;

    // clamp a 16-bit tick register into the counter range
    function automatic timer_t timer_load(input logic [15:0] v);
        timer_t t;
        if ({17'b0, v} > TIMER_MAX)
            t = '1;
        else
            t = TIMER_BITS'(v);
        return t;
    endfunction

endpackage

// ===== sv/dtmfseq_in_stage.sv =====
`timescale 1ns / 1ps

module dtmfseq_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  dtmfseq_pkg::item_t  s_item,
    input  logic                take,
    output logic                item_valid,
    output dtmfseq_pkg::item_t  item
);
    import dtmfseq_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // space when empty or when the held word moves on this cycle
    assign s_tready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
            valid_next = s_tvalid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            item_reg <= s_item;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== sv/dtmfseq_engine.sv =====
`timescale 1ns / 1ps

module dtmfseq_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  step,
    input  dtmfseq_pkg::item_t    item,
    output dtmfseq_pkg::result_t  result
);
    import dtmfseq_pkg::*;

    // configuration registers
    logic [31:0] code_reg;
    logic [15:0] guard_ticks_reg;
    logic [15:0] hangup_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg         <= CODE_RESET;
            guard_ticks_reg  <= GUARD_RESET;
            hangup_ticks_reg <= HANGUP_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_CODE_DIGITS:  code_reg         <= cfg_data;
                REG_GUARD_TICKS:  guard_ticks_reg  <= cfg_data[15:0];
                REG_HANGUP_TICKS: hangup_ticks_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sequencer state
    phase_t     phase_reg,         phase_next;
    digit_idx_t digit_idx_reg,     digit_idx_next;
    timer_t     guard_count_reg,   guard_count_next;
    logic       guard_running_reg, guard_running_next;
    timer_t     delay_count_reg,   delay_count_next;
    logic       delay_running_reg, delay_running_next;
    logic       delay_expired_reg, delay_expired_next;

    op_t         op;
    logic        guard_fired;
    logic        delay_fired;
    logic        delay_exp_now;
    logic        in_digits;
    logic        is_done;
    logic        digit_match;
    logic        last_digit;
    logic [CODE_EXT_W-1:0] code_ext;
    digit_idx_t  rev_idx;
    logic [7:0]  expected;

    assign op = op_t'(item.op);

    // timer decode for a tick
    assign guard_fired   = guard_running_reg && (guard_count_reg <= timer_t'(1));
    assign delay_fired   = delay_running_reg && (delay_count_reg <= timer_t'(1));
    assign delay_exp_now = delay_expired_reg || delay_fired;

    assign in_digits = (phase_reg == PH_DIGITS);
    assign is_done   = phase_reg inside {PH_DONE_RESET, PH_DONE_DELAYED};

    // expected character: first digit in the highest used byte
    assign code_ext    = CODE_EXT_W'(code_reg);
    assign rev_idx     = digit_idx_t'(CODE_DIGITS - 1) - digit_idx_reg;
    assign expected    = code_ext[{rev_idx, 3'b000} +: 8];
    assign digit_match = (item.digit == expected);
    assign last_digit  = (digit_idx_reg == digit_idx_t'(CODE_DIGITS - 1));

    // next state
    always_comb
    begin
        phase_next         = phase_reg;
        digit_idx_next     = digit_idx_reg;
        guard_count_next   = guard_count_reg;
        guard_running_next = guard_running_reg;
        delay_count_next   = delay_count_reg;
        delay_running_next = delay_running_reg;
        delay_expired_next = delay_expired_reg;

        if (op == OP_START)
        begin
            guard_count_next   = '0;
            guard_running_next = 1'b0;
            delay_count_next   = '0;
            delay_running_next = 1'b0;
            delay_expired_next = 1'b0;
            phase_next         = PH_WAIT_DDET_OK;
        end
        else if (!is_done)
        begin
            case (op)
                OP_TICK:
                begin
                    if (guard_running_reg)
                    begin
                        if (guard_fired)
                        begin
                            guard_count_next   = '0;
                            guard_running_next = 1'b0;
                        end
                        else
                            guard_count_next = guard_count_reg - timer_t'(1);
                    end
                    if (delay_running_reg)
                    begin
                        if (delay_fired)
                        begin
                            delay_count_next   = '0;
                            delay_running_next = 1'b0;
                            delay_expired_next = 1'b1;
                        end
                        else
                            delay_count_next = delay_count_reg - timer_t'(1);
                    end
                    if (guard_fired)
                    begin
                        delay_count_next   = timer_load(hangup_ticks_reg);
                        delay_running_next = 1'b1;
                        delay_expired_next = 1'b0;
                        phase_next         = PH_RESET_DELAY;
                    end
                    else if (delay_exp_now)
                    begin
                        if (phase_reg == PH_DELAY_HANGUP)
                        begin
                            delay_count_next   = timer_load(hangup_ticks_reg);
                            delay_running_next = 1'b1;
                            delay_expired_next = 1'b0;
                            phase_next         = PH_WAIT_ATH_OK;
                        end
                        else if (phase_reg == PH_FINAL_DELAY ||
                                 phase_reg == PH_RESET_DELAY)
                        begin
                            guard_count_next   = '0;
                            guard_running_next = 1'b0;
                            delay_count_next   = '0;
                            delay_running_next = 1'b0;
                            delay_expired_next = 1'b0;
                            phase_next = (phase_reg == PH_FINAL_DELAY) ?
                                         PH_DONE_DELAYED : PH_DONE_RESET;
                        end
                    end
                end
                OP_MODEM_OK:
                begin
                    case (phase_reg)
                        PH_WAIT_DDET_OK:
                        begin
                            guard_count_next   = timer_load(guard_ticks_reg);
                            guard_running_next = 1'b1;
                            phase_next         = PH_WAIT_ATA_OK;
                        end
                        PH_WAIT_ATA_OK:
                        begin
                            digit_idx_next = '0;
                            phase_next     = PH_DIGITS;
                        end
                        PH_WAIT_VTD_OK:
                            phase_next = PH_WAIT_VTS_OK;
                        PH_WAIT_VTS_OK:
                        begin
                            delay_count_next   = timer_load(hangup_ticks_reg);
                            delay_running_next = 1'b1;
                            delay_expired_next = 1'b0;
                            phase_next         = PH_DELAY_HANGUP;
                        end
                        PH_WAIT_ATH_OK:
                        begin
                            if (delay_expired_reg)
                            begin
                                guard_count_next   = '0;
                                guard_running_next = 1'b0;
                                delay_count_next   = '0;
                                delay_running_next = 1'b0;
                                delay_expired_next = 1'b0;
                                phase_next         = PH_DONE_DELAYED;
                            end
                            else
                                phase_next = PH_FINAL_DELAY;
                        end
                        default: ;
                    endcase
                end
                OP_DIGIT:
                begin
                    if (in_digits)
                    begin
                        if (!digit_match)
                            digit_idx_next = '0;
                        else if (last_digit)
                        begin
                            guard_count_next   = '0;
                            guard_running_next = 1'b0;
                            phase_next         = PH_WAIT_VTD_OK;
                        end
                        else
                            digit_idx_next = digit_idx_reg + digit_idx_t'(1);
                    end
                end
                OP_CARRIER_LOST:
                begin
                    if (in_digits)
                    begin
                        guard_count_next   = '0;
                        guard_running_next = 1'b0;
                        delay_count_next   = '0;
                        delay_running_next = 1'b0;
                        delay_expired_next = 1'b0;
                        phase_next         = PH_DONE_RESET;
                    end
                end
                default: ;
            endcase
        end
    end

    // result word
    always_comb
    begin
        result.command   = CMD_NONE;
        result.exit_mode = EXIT_RUNNING;

        if (op == OP_START)
            result.command = CMD_DDET_ON;
        else if (phase_reg == PH_DONE_RESET)
            result.exit_mode = EXIT_RESET;
        else if (phase_reg == PH_DONE_DELAYED)
            result.exit_mode = EXIT_DELAYED;
        else
        begin
            case (op)
                OP_TICK:
                begin
                    if (guard_fired)
                        result.command = CMD_HANG_UP;
                    else if (delay_exp_now)
                    begin
                        if (phase_reg == PH_DELAY_HANGUP)
                            result.command = CMD_HANG_UP;
                        else if (phase_reg == PH_FINAL_DELAY)
                            result.exit_mode = EXIT_DELAYED;
                        else if (phase_reg == PH_RESET_DELAY)
                            result.exit_mode = EXIT_RESET;
                    end
                end
                OP_MODEM_OK:
                begin
                    if (phase_reg == PH_WAIT_DDET_OK)
                        result.command = CMD_ANSWER;
                    else if (phase_reg == PH_WAIT_VTD_OK)
                        result.command = CMD_SEND_TONE;
                    else if (phase_reg == PH_WAIT_ATH_OK && delay_expired_reg)
                        result.exit_mode = EXIT_DELAYED;
                end
                OP_DIGIT:
                begin
                    if (in_digits && digit_match && last_digit)
                        result.command = CMD_TONE_LEN;
                end
                OP_CARRIER_LOST:
                begin
                    if (in_digits)
                        result.exit_mode = EXIT_RESET;
                end
                default: ;
            endcase
        end
    end

    // state update on each processed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            digit_idx_reg     <= '0;
            guard_count_reg   <= '0;
            guard_running_reg <= 1'b0;
            delay_count_reg   <= '0;
            delay_running_reg <= 1'b0;
            delay_expired_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            digit_idx_reg     <= digit_idx_next;
            guard_count_reg   <= guard_count_next;
            guard_running_reg <= guard_running_next;
            delay_count_reg   <= delay_count_next;
            delay_running_reg <= delay_running_next;
            delay_expired_reg <= delay_expired_next;
        end
    end

endmodule

// ===== sv/dtmfseq_out_stage.sv =====
`timescale 1ns / 1ps

module dtmfseq_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  dtmfseq_pkg::result_t  result,
    output logic                  can_load,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output dtmfseq_pkg::result_t  m_result
);
    import dtmfseq_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // free when empty or when the held word leaves this cycle
    assign can_load = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result;
    end

    assign m_tvalid = valid_reg;
    assign m_result = result_reg;

endmodule

// ===== sv/dtmf_code_disarm_call_sequencer.sv =====
`timescale 1ns / 1ps
// an accepted word is held in the input register, its result word in the result register
// throughput: one event word per cycle, stalls only when the result register is held
// the event logic sits between the input register and the result register
// reset (rst_n, async, active low): phase idle, timers cleared, both stages empty,
// code and tick registers back to their defaults

module dtmf_code_disarm_call_sequencer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [31:0]                         cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dtmfseq_pkg::IN_TDATA_W-1:0]  s_tdata,   // op[2:0], digit[10:3]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dtmfseq_pkg::OUT_TDATA_W-1:0] m_tdata    // command[2:0], exit_mode[4:3]
);
    import dtmfseq_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    can_load;
    logic    step;
    result_t result;
    result_t m_result;

    assign s_item.op    = s_tdata[2:0];
    assign s_item.digit = s_tdata[10:3];

    // advance when a word is held and the result register has room
    assign step = item_valid && can_load;

    dtmfseq_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    dtmfseq_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .item      (item),
        .result    (result)
    );

    dtmfseq_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .result   (result),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {3'b000, m_result.exit_mode, m_result.command};

endmodule

// ===== sv/dtmfseq_checker.sv =====
`timescale 1ns / 1ps

module dtmfseq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // held result word stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // only defined command codes
    a_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= 3'd5)
        else $error("undefined command code");

    // exit codes in range and pad bits clear
    a_exit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[4:3] != 2'b11 && m_tdata[7:5] == 3'b000)
        else $error("bad exit code or pad bits");

    // an exit never comes with a modem command
    a_exit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4:3] != 2'b00 |-> m_tdata[2:0] == 3'd0)
        else $error("command issued alongside an exit");

endmodule

bind dtmf_code_disarm_call_sequencer dtmfseq_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/tb_dtmf_code_disarm_call_sequencer.sv =====
`timescale 1ns / 1ps

module tb_dtmf_code_disarm_call_sequencer;

    import dtmfseq_pkg::*;

    // clock and block inputs, all known from time zero
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [1:0]             cfg_index = '0;
    logic [31:0]            cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;    // op[2:0], digit[10:3]
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;           // command[2:0], exit_mode[4:3]

    // traffic shaping, in percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // bookkeeping of the result stream
    result_t expected_results[$];
    int      fail_count = 0;
    int      items_sent = 0;

    // shadow copy of the sequencer registers and state
    logic [31:0] code_reg;
    logic [15:0] guard_ticks;
    logic [15:0] hangup_ticks;
    logic [4:0]  seq_phase;
    timer_t      guard_cnt;
    logic        guard_on;
    timer_t      delay_cnt;
    logic        delay_on;
    logic        delay_done;

    dtmf_code_disarm_call_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // timer load with clamp to the counter range
    function automatic timer_t load_ticks(input logic [15:0] v);
        return ({17'b0, v} > TIMER_MAX) ? '1 : timer_t'(v);
    endfunction

    // expected character k of the disarm code, first one in the top byte
    function automatic logic [7:0] code_char(input int k);
        return 8'(code_reg >> (8 * (CODE_DIGITS - 1 - k)));
    endfunction

    function automatic void clear_timers();
        guard_cnt  = '0;
        guard_on   = 1'b0;
        delay_cnt  = '0;
        delay_on   = 1'b0;
        delay_done = 1'b0;
    endfunction

    function automatic void arm_delay();
        delay_cnt  = load_ticks(hangup_ticks);
        delay_on   = 1'b1;
        delay_done = 1'b0;
    endfunction

    // next state and result word of the sequencer for one event
    function automatic result_t predict_event(input logic [2:0] op, input logic [7:0] digit);
        result_t r;
        logic    guard_fired;
        logic    in_digits;
        int      k;
        r.command   = CMD_NONE;
        r.exit_mode = EXIT_RUNNING;
        guard_fired = 1'b0;
        in_digits   = (seq_phase >= PH_DIGITS) && (seq_phase < PH_DIGITS + CODE_DIGITS);
        k           = int'(seq_phase) - int'(PH_DIGITS);
        if (op == OP_START)
        begin
            clear_timers();
            r.command = CMD_DDET_ON;
            seq_phase = PH_WAIT_DDET_OK;
        end
        else if (seq_phase == PH_DONE_RESET)
            r.exit_mode = EXIT_RESET;
        else if (seq_phase == PH_DONE_DELAYED)
            r.exit_mode = EXIT_DELAYED;
        else
        begin
            case (op)
                OP_TICK:
                begin
                    if (guard_on)
                    begin
                        if (guard_cnt <= 1)
                        begin
                            guard_cnt   = '0;
                            guard_on    = 1'b0;
                            guard_fired = 1'b1;
                        end
                        else
                            guard_cnt = guard_cnt - 1'b1;
                    end
                    if (delay_on)
                    begin
                        if (delay_cnt <= 1)
                        begin
                            delay_cnt  = '0;
                            delay_on   = 1'b0;
                            delay_done = 1'b1;
                        end
                        else
                            delay_cnt = delay_cnt - 1'b1;
                    end
                    if (guard_fired)
                    begin
                        r.command = CMD_HANG_UP;
                        arm_delay();
                        seq_phase = PH_RESET_DELAY;
                    end
                    else if (delay_done)
                    begin
                        case (seq_phase)
                            PH_DELAY_HANGUP:
                            begin
                                r.command = CMD_HANG_UP;
                                arm_delay();
                                seq_phase = PH_WAIT_ATH_OK;
                            end
                            PH_FINAL_DELAY:
                            begin
                                clear_timers();
                                r.exit_mode = EXIT_DELAYED;
                                seq_phase   = PH_DONE_DELAYED;
                            end
                            PH_RESET_DELAY:
                            begin
                                clear_timers();
                                r.exit_mode = EXIT_RESET;
                                seq_phase   = PH_DONE_RESET;
                            end
                            default: ;
                        endcase
                    end
                end
                OP_MODEM_OK:
                begin
                    case (seq_phase)
                        PH_WAIT_DDET_OK:
                        begin
                            r.command = CMD_ANSWER;
                            guard_cnt = load_ticks(guard_ticks);
                            guard_on  = 1'b1;
                            seq_phase = PH_WAIT_ATA_OK;
                        end
                        PH_WAIT_ATA_OK:
                            seq_phase = PH_DIGITS;
                        PH_WAIT_VTD_OK:
                        begin
                            r.command = CMD_SEND_TONE;
                            seq_phase = PH_WAIT_VTS_OK;
                        end
                        PH_WAIT_VTS_OK:
                        begin
                            arm_delay();
                            seq_phase = PH_DELAY_HANGUP;
                        end
                        PH_WAIT_ATH_OK:
                        begin
                            // an expiry latched before this ok ends the call at once
                            if (delay_done)
                            begin
                                clear_timers();
                                r.exit_mode = EXIT_DELAYED;
                                seq_phase   = PH_DONE_DELAYED;
                            end
                            else
                                seq_phase = PH_FINAL_DELAY;
                        end
                        default: ;
                    endcase
                end
                OP_DIGIT:
                begin
                    if (in_digits)
                    begin
                        if (digit != code_char(k))
                            seq_phase = PH_DIGITS;
                        else if (k + 1 >= CODE_DIGITS)
                        begin
                            guard_cnt = '0;
                            guard_on  = 1'b0;
                            r.command = CMD_TONE_LEN;
                            seq_phase = PH_WAIT_VTD_OK;
                        end
                        else
                            seq_phase = seq_phase + 1'b1;
                    end
                end
                OP_CARRIER_LOST:
                begin
                    if (in_digits)
                    begin
                        clear_timers();
                        r.exit_mode = EXIT_RESET;
                        seq_phase   = PH_DONE_RESET;
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    // result word checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result word: command %0d exit %0d",
                             m_tdata[2:0], m_tdata[4:3]);
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[2:0] !== want.command || m_tdata[4:3] !== want.exit_mode)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected command %0d exit %0d, got command %0d exit %0d",
                                 want.command, want.exit_mode, m_tdata[2:0], m_tdata[4:3]);
                end
            end
        end
    end

    // offer one event word, with random gaps in front of it
    task automatic send_event(input logic [2:0] op, input logic [7:0] digit);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, digit, op};
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(predict_event(op, digit));
        items_sent++;
    endtask

    // hold the input side until every pending result word is out
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write all three registers while the block is idle
    task automatic load_config(input logic [31:0] code, input logic [15:0] guard,
                               input logic [15:0] hangup);
        wait_all_results();
        cfg_we    <= 1'b1;
        cfg_index <= REG_CODE_DIGITS;
        cfg_data  <= code;
        @(posedge clk);
        cfg_index <= REG_GUARD_TICKS;
        cfg_data  <= {16'($urandom), guard};
        @(posedge clk);
        cfg_index <= REG_HANGUP_TICKS;
        cfg_data  <= {16'($urandom), hangup};
        @(posedge clk);
        cfg_we       <= 1'b0;
        code_reg     = code;
        guard_ticks  = guard;
        hangup_ticks = hangup;
    endtask

    // reset register values, stray events, wrong digit, restart and carrier loss
    task automatic test_default_registers();
        send_event(OP_TICK, 8'h00);
        send_event(OP_DIGIT, 8'hFF);
        send_event(3'd7, 8'h55);
        send_event(OP_START, 8'h00);
        send_event(OP_CARRIER_LOST, 8'h00);
        send_event(OP_MODEM_OK, 8'h00);
        send_event(OP_DIGIT, "2");
        send_event(OP_MODEM_OK, 8'h00);
        send_event(OP_DIGIT, "2");
        send_event(OP_DIGIT, "5");
        send_event(OP_DIGIT, "0");
        send_event(OP_DIGIT, "2");
        send_event(OP_DIGIT, "5");
        send_event(OP_DIGIT, "8");
        send_event(OP_DIGIT, "#");
        send_event(OP_MODEM_OK, 8'h00);
        send_event(OP_MODEM_OK, 8'h00);
        send_event(OP_START, 8'hAA);
        send_event(OP_MODEM_OK, 8'h00);
        send_event(OP_MODEM_OK, 8'h00);
        send_event(OP_DIGIT, "2");
        send_event(OP_CARRIER_LOST, 8'h00);
        send_event(OP_MODEM_OK, 8'h00);
        send_event(3'd5, 8'h00);
    endtask

    // zero guard load, guard timeout, and delay expiry latched before the hang-up ok
    task automatic test_timer_corners();
        load_config(32'hFFFF_FFFF, 16'd0, 16'd1);
        send_event(OP_START, 8'h00);
        send_event(OP_MODEM_OK, 8'h00);
        send_event(OP_TICK, 8'h00);
        send_event(OP_TICK, 8'h00);
        send_event(3'd6, 8'hFF);
        send_event(OP_START, 8'h00);
        send_event(OP_MODEM_OK, 8'h00);
        send_event(OP_MODEM_OK, 8'h00);
        repeat (CODE_DIGITS) send_event(OP_DIGIT, 8'hFF);
        send_event(OP_MODEM_OK, 8'h00);
        send_event(OP_MODEM_OK, 8'h00);
        send_event(OP_TICK, 8'h00);
        send_event(OP_TICK, 8'h00);
        send_event(OP_MODEM_OK, 8'h00);
    endtask

    // largest guard count, hang-up delays run out in full on the success path
    task automatic test_long_hangup();
        int k;
        load_config(32'h0000_0000, 16'hFFFF, 16'd40);
        send_event(OP_START, 8'h00);
        send_event(OP_MODEM_OK, 8'h00);
        send_event(OP_MODEM_OK, 8'h00);
        send_event(OP_DIGIT, 8'h80);
        for (k = 0; k < CODE_DIGITS; k++)
            send_event(OP_DIGIT, 8'h00);
        send_event(OP_MODEM_OK, 8'h00);
        send_event(OP_MODEM_OK, 8'h00);
        while (seq_phase != PH_DONE_DELAYED && seq_phase != PH_DONE_RESET)
        begin
            if (seq_phase == PH_WAIT_ATH_OK && delay_cnt == 16'd10)
                send_event(OP_MODEM_OK, 8'h00);
            else
                send_event(OP_TICK, 8'h00);
        end
        send_event(OP_TICK, 8'h00);
    endtask

    // one call driven mostly by the events each phase waits for, with noise mixed in
    task automatic play_call(input int max_events);
        int n;
        int pick;
        int sub;
        n = 0;
        send_event(OP_START, 8'($urandom));
        while (n < max_events && seq_phase != PH_DONE_RESET && seq_phase != PH_DONE_DELAYED)
        begin
            pick = $urandom_range(99);
            sub  = $urandom_range(99);
            if (pick < 1)
                send_event(OP_START, 8'($urandom));
            else if (pick < 11)
                send_event(3'($urandom_range(1, 7)), 8'($urandom));
            else if (seq_phase >= PH_DIGITS && seq_phase < PH_DIGITS + CODE_DIGITS)
            begin
                if (sub < 82)
                    send_event(OP_DIGIT, code_char(int'(seq_phase) - int'(PH_DIGITS)));
                else if (sub < 92)
                    send_event(OP_DIGIT, 8'($urandom));
                else if (sub < 97)
                    send_event(OP_TICK, 8'($urandom));
                else
                    send_event(OP_CARRIER_LOST, 8'($urandom));
            end
            else if (seq_phase == PH_WAIT_ATH_OK)
                send_event((sub < 50) ? OP_MODEM_OK : OP_TICK, 8'($urandom));
            else if (seq_phase == PH_DELAY_HANGUP || seq_phase == PH_FINAL_DELAY ||
                     seq_phase == PH_RESET_DELAY)
                send_event(OP_TICK, 8'($urandom));
            else
                send_event((sub < 90) ? OP_MODEM_OK : OP_TICK, 8'($urandom));
            n++;
        end
        // one or two events other than start, which leave the state alone once the call has exited
        repeat ($urandom_range(1, 2)) send_event(3'($urandom_range(1, 7)), 8'($urandom));
    endtask

    // random calls under one traffic shape, with new register settings along the way
    task automatic test_random_calls(input int idle_pct, input int stall_pct, input int count);
        int          start;
        int          last_cfg;
        logic [15:0] guard;
        logic [15:0] hangup;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start    = items_sent;
        last_cfg = items_sent;
        while (items_sent - start < count)
        begin
            if (items_sent == start || items_sent - last_cfg >= 60)
            begin
                guard    = ($urandom_range(9) == 0) ? 16'($urandom_range(1)) :
                                                      16'($urandom_range(2, 40));
                hangup   = 16'($urandom_range(0, 6));
                load_config($urandom, guard, hangup);
                last_cfg = items_sent;
            end
            else if ($urandom_range(7) == 0)
                wait_all_results();
            play_call(60);
        end
        wait_all_results();
    endtask

    // watchdog
    initial
    begin
        #20_000_000;
        $display("[dtmf_code_disarm_call_sequencer] ERROR");
        $finish;
    end

    // test sequence
    initial
    begin
        int spin;
        code_reg     = CODE_RESET;
        guard_ticks  = GUARD_RESET;
        hangup_ticks = HANGUP_RESET;
        seq_phase    = PH_IDLE;
        clear_timers();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_registers();
        test_timer_corners();
        test_long_hangup();
        test_random_calls(0, 0, 140);
        test_random_calls(50, 0, 140);
        test_random_calls(0, 50, 140);
        test_random_calls(25, 25, 140);

        s_tvalid <= 1'b0;
        spin = 0;
        while (expected_results.size() != 0 && spin < 2000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (8) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("[dtmf_code_disarm_call_sequencer] OK");
        else
            $display("[dtmf_code_disarm_call_sequencer] ERROR");
        $finish;
    end

endmodule
